// File: hdl/rfba_pkg.sv
// Shared constants, types and codes of the fragment byte accumulator.
package rfba_pkg;

  localparam logic [31:0] PART_SIZE     = 32'd9728000;
  localparam int          NUM_FRAGMENTS = 512;

  localparam int IDX_W  = (NUM_FRAGMENTS > 1) ? $clog2(NUM_FRAGMENTS) : 1;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = OFF_W + 1;
  localparam int RIDX_W = 9;
  localparam int MODE_W = 2;

  // bytes [0, TABLE_END) are covered by the table
  localparam logic [63:0] TABLE_END = 64'(PART_SIZE) * 64'(NUM_FRAGMENTS);

  // floor(2^32 / PART_SIZE); estimate from it is the quotient or one short
  localparam logic [OFF_W:0] RECIP = 33'((64'd1 << 32) / 64'(PART_SIZE));

  localparam int                CNT_W     = 48;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam int                TOUCH_W   = 10;
  localparam logic [TOUCH_W-1:0] TOUCH_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_END  = 2'd0,
    MODE_LEN  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_LOCATE,
    S_WALK,
    S_READ,
    S_DONE
  } state_t;

  // first fragment of a range and the bytes left in it from the start offset
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] avail;
  } frag_pos_t;

endpackage

// File: hdl/range_to_fragment_byte_accumulator.sv
// Top level: range splitting sequencer around the fragment counter memory.
//
// Each transaction is a byte range (by end offset or by length) or a read of one
// counter. A range is handled in steps: the range is clamped, the
// reciprocal divide that finds the first fragment is finished, then there is
// one read-modify-write of the counter memory per fragment, the read of the
// next fragment overlapping the write-back of the current one. Reads, empty
// ranges, reversed ranges and the unused mode finish without a walk. After
// reset the counter memory is zeroed by a sweep over all NUM_FRAGMENTS (512)
// counters, during which in_ready stays low. A result waiting in the output
// register does not stop the next transaction being taken.
module range_to_fragment_byte_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rfba_pkg::MODE_W-1:0]   in_mode,
  input  logic [rfba_pkg::OFF_W-1:0]    in_range_start,
  input  logic [rfba_pkg::OFF_W-1:0]    in_range_value,
  input  logic [rfba_pkg::RIDX_W-1:0]   in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfba_pkg::CNT_W-1:0]    out_read_count,
  output logic [rfba_pkg::TOUCH_W-1:0]  out_fragments_touched,
  output logic                          out_range_error
);
  import rfba_pkg::*;

  state_t               state_r,     state_nxt;
  logic [IDX_W-1:0]     clr_r,       clr_nxt;
  mode_t                mode_r,      mode_nxt;
  logic [OFF_W-1:0]     start_r,     start_nxt;
  logic [OFF_W-1:0]     value_r,     value_nxt;
  logic [LEN_W-1:0]     len_r,       len_nxt;
  logic [IDX_W-1:0]     idx_r,       idx_nxt;
  logic [OFF_W-1:0]     avail_r,     avail_nxt;
  logic [TOUCH_W-1:0]   touched_r,   touched_nxt;
  logic                 err_r,       err_nxt;
  logic [CNT_W-1:0]     rcount_r,    rcount_nxt;
  logic                 rd_oor_r,    rd_oor_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;
  logic [TOUCH_W-1:0]   out_touch_r, out_touch_nxt;
  logic                 out_err_r,   out_err_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 fin;
  logic [CNT_W-1:0]     fin_count;
  logic [TOUCH_W-1:0]   fin_touched;
  logic                 fin_err;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [CNT_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [CNT_W-1:0]     ram_rdata;

  frag_pos_t            pos;

  // range preparation
  logic [LEN_W-1:0]     end_c;
  logic [LEN_W-1:0]     end_cl;
  logic                 backward;
  logic                 nonzero;
  logic                 over;
  logic                 walk;
  logic [LEN_W-1:0]     len_c;

  // per-fragment update
  logic [OFF_W-1:0]     chunk;
  logic [CNT_W:0]       sum;
  logic [LEN_W-1:0]     len_left;
  logic [TOUCH_W-1:0]   touched_inc;

  assign in_ready              = (state_r == S_IDLE);
  assign accept                = in_valid && in_ready;
  assign out_free              = !out_valid_r || out_ready;
  assign out_valid             = out_valid_r;
  assign out_read_count        = out_count_r;
  assign out_fragments_touched = out_touch_r;
  assign out_range_error       = out_err_r;

  rfba_ram #(
    .DEPTH (NUM_FRAGMENTS),
    .WIDTH (CNT_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rfba_frag_div u_div (
    .clk   (clk),
    .load  (accept),
    .start (in_range_start),
    .pos   (pos)
  );

  always_comb begin
    end_c    = (mode_r == MODE_END) ? {1'b0, value_r}
                                    : ({1'b0, start_r} + {1'b0, value_r});
    backward = (mode_r == MODE_END) && (value_r < start_r);
    nonzero  = (mode_r inside {MODE_END, MODE_LEN}) && (end_c > {1'b0, start_r});
    over     = nonzero && (64'(end_c) > TABLE_END);
    end_cl   = over ? TABLE_END[LEN_W-1:0] : end_c;
    walk     = nonzero && (end_cl > {1'b0, start_r});
    len_c    = end_cl - {1'b0, start_r};
  end

  always_comb begin
    chunk       = (len_r < {1'b0, avail_r}) ? len_r[OFF_W-1:0] : avail_r;
    sum         = {1'b0, ram_rdata} + (CNT_W+1)'(chunk);
    len_left    = len_r - {1'b0, chunk};
    touched_inc = (touched_r == TOUCH_MAX) ? TOUCH_MAX : touched_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mode_nxt      = mode_r;
    start_nxt     = start_r;
    value_nxt     = value_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    avail_nxt     = avail_r;
    touched_nxt   = touched_r;
    err_nxt       = err_r;
    rcount_nxt    = rcount_r;
    rd_oor_nxt    = rd_oor_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    out_touch_nxt = out_touch_r;
    out_err_nxt   = out_err_r;

    fin         = 1'b0;
    fin_count   = rcount_r;
    fin_touched = touched_r;
    fin_err     = err_r;

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (32'(clr_r) == NUM_FRAGMENTS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = mode_t'(in_mode);
          start_nxt = in_range_start;
          value_nxt = in_range_value;
          if (mode_t'(in_mode) == MODE_READ) begin
            rd_oor_nxt = (32'(in_read_index) >= NUM_FRAGMENTS);
            ram_re     = (32'(in_read_index) < NUM_FRAGMENTS);
            ram_raddr  = IDX_W'(in_read_index);
            state_nxt  = S_READ;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        rcount_nxt  = '0;
        touched_nxt = '0;
        err_nxt     = backward || over;
        len_nxt     = len_c;
        if (walk) begin
          state_nxt = S_LOCATE;
        end else begin
          fin         = 1'b1;
          fin_count   = '0;
          fin_touched = '0;
          fin_err     = backward || over;
        end
      end
      S_LOCATE: begin
        idx_nxt   = pos.idx;
        avail_nxt = pos.avail;
        ram_re    = 1'b1;
        ram_raddr = pos.idx;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        ram_we      = 1'b1;
        ram_waddr   = idx_r;
        ram_wdata   = (sum >= {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
        len_nxt     = len_left;
        touched_nxt = touched_inc;
        if (len_left != '0) begin
          // later fragments are entered at their first byte
          idx_nxt   = idx_r + 1'b1;
          avail_nxt = PART_SIZE;
          ram_re    = 1'b1;
          ram_raddr = idx_r + 1'b1;
        end else begin
          fin         = 1'b1;
          fin_touched = touched_inc;
        end
      end
      S_READ: begin
        fin         = 1'b1;
        fin_count   = rd_oor_r ? '0 : ram_rdata;
        fin_touched = '0;
        fin_err     = 1'b0;
        rcount_nxt  = fin_count;
        touched_nxt = '0;
        err_nxt     = 1'b0;
      end
      S_DONE: begin
        fin = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result goes straight to the output register when it is free
    if (fin) begin
      rcount_nxt  = fin_count;
      touched_nxt = fin_touched;
      err_nxt     = fin_err;
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_count_nxt = fin_count;
        out_touch_nxt = fin_touched;
        out_err_nxt   = fin_err;
        state_nxt     = S_IDLE;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    start_r     <= start_nxt;
    value_r     <= value_nxt;
    len_r       <= len_nxt;
    idx_r       <= idx_nxt;
    avail_r     <= avail_nxt;
    touched_r   <= touched_nxt;
    err_r       <= err_nxt;
    rcount_r    <= rcount_nxt;
    rd_oor_r    <= rd_oor_nxt;
    out_count_r <= out_count_nxt;
    out_touch_r <= out_touch_nxt;
    out_err_r   <= out_err_nxt;
  end

  // read and write of the same counter in one cycle would need forwarding
  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("counter read and written at the same address");

  a_write_only_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_CLEAR) || (state_r == S_WALK)))
    else $error("counter write outside clear or walk");

  a_walk_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((len_r != '0) && (avail_r != '0)))
    else $error("walk step with no bytes left");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (32'(idx_r) < NUM_FRAGMENTS))
    else $error("walk beyond the last fragment");

  a_result_follows_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WALK) && (len_left == '0) && out_free) |=> (out_valid && (state_r == S_IDLE)))
    else $error("walk finished without a result");

endmodule

// File: hdl/rfba_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module rfba_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 48,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/rfba_frag_div.sv
// Start offset to fragment index and remaining bytes, by reciprocal multiply.
module rfba_frag_div (
  input  logic                         clk,
  input  logic                         load,
  input  logic [rfba_pkg::OFF_W-1:0]   start,
  output rfba_pkg::frag_pos_t          pos
);
  import rfba_pkg::*;

  logic [OFF_W-1:0]  start_r;
  logic [OFF_W-1:0]  qest_r;
  logic [OFF_W-1:0]  prod_r;
  logic [64:0]       scaled;
  logic [63:0]       prod_full;
  logic [OFF_W-1:0]  diff;
  logic [OFF_W-1:0]  q;
  logic [OFF_W-1:0]  off;

  assign scaled    = 65'(start) * 65'(RECIP);
  assign prod_full = 64'(qest_r) * 64'(PART_SIZE);

  // stage 1 on load, stage 2 free-running; pos is valid once stage 2 holds the product
  always_ff @(posedge clk) begin
    if (load) begin
      start_r <= start;
      qest_r  <= scaled[63:32];
    end
    prod_r <= prod_full[OFF_W-1:0];
  end

  // estimate is at most one below the true quotient
  always_comb begin
    diff = start_r - prod_r;
    if (diff >= PART_SIZE) begin
      q   = qest_r + 1'b1;
      off = diff - PART_SIZE;
    end else begin
      q   = qest_r;
      off = diff;
    end
    pos.idx   = q[IDX_W-1:0];
    pos.avail = PART_SIZE - off;
  end

endmodule
